FILE: hw/rtl/selective_repeat_receiver_window_assert.svh
// Assertion macros for the receiver window RTL, used by srrw_back.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/srrw_pkg.sv
// Shared types, constants and checksum helpers for the receiver window.
// No dependencies; imported by every module of the block.
`default_nettype none

package srrw_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int WIN_W      = 6;
  localparam int SEQ_W      = 31;
  localparam int PSUM_W     = 11;

  localparam logic [WIN_W-1:0] WIN_RESET   = 6'd32;
  localparam logic [WIN_W-1:0] WIN_MAX     = 6'(SLOT_COUNT);
  localparam logic [31:0]      ACK_SPACE   = 32'd32;
  localparam logic             KIND_ACK    = 1'b0;
  localparam logic             KIND_DATA   = 1'b1;
  localparam logic             FLAG_DUP    = 1'b0;
  localparam logic             FLAG_WINDOW = 1'b1;

  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] plo;
    logic [63:0] pmid;
    logic [31:0] phi;
  } pkt_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SEND = 3'b100
  } bstate_t;

  // Sum of the eight bytes of a word, each taken as a signed value.
  function automatic logic signed [PSUM_W-1:0] byte_sum8(input logic [63:0] w);
    logic signed [PSUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + PSUM_W'(signed'(w[8*i +: 8]));
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srrw_front.sv
// Front end: registers each incoming request with its byte sums and checks the checksum.
// Passing packets are pushed into the queue; failing ones are dropped. Uses srrw_pkg.
`default_nettype none

module srrw_front import srrw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] seq_num,
  input  wire logic [31:0] ack_field,
  input  wire logic [31:0] check_value,
  input  wire logic [63:0] payload_low,
  input  wire logic [63:0] payload_mid,
  input  wire logic [31:0] payload_high,
  output logic             push,
  output pkt_t             push_pkt,
  input  wire logic        q_full
);

  logic                     s1_valid_r, s1_valid_nxt;
  pkt_t                     s1_pkt_r;
  logic [31:0]              s1_ack_r;
  logic [31:0]              s1_chk_r;
  logic signed [PSUM_W-1:0] s1_plo_r, s1_pmid_r, s1_phi_r;
  logic [31:0]              total;
  logic                     pass;
  logic                     s1_go;
  logic                     accept;

  assign total = s1_pkt_r.seq + s1_ack_r
               + {{(32-PSUM_W){s1_plo_r[PSUM_W-1]}}, s1_plo_r}
               + {{(32-PSUM_W){s1_pmid_r[PSUM_W-1]}}, s1_pmid_r}
               + {{(32-PSUM_W){s1_phi_r[PSUM_W-1]}}, s1_phi_r};
  assign pass     = (total == s1_chk_r);
  assign s1_go    = s1_valid_r && (!pass || !q_full);
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid_r && pass && !q_full;
  assign push_pkt = s1_pkt_r;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pkt_r.seq  <= seq_num;
      s1_pkt_r.plo  <= payload_low;
      s1_pkt_r.pmid <= payload_mid;
      s1_pkt_r.phi  <= payload_high;
      s1_ack_r      <= ack_field;
      s1_chk_r      <= check_value;
      s1_plo_r      <= byte_sum8(payload_low);
      s1_pmid_r     <= byte_sum8(payload_mid);
      s1_phi_r      <= byte_sum8({32'h0, payload_high});
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srrw_queue.sv
// Two-entry queue between the checksum front end and the window back end.
// Holds checked packets; uses pkt_t from srrw_pkg.
`default_nettype none

module srrw_queue import srrw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  output logic      full,
  output logic      q_valid,
  output pkt_t      head,
  input  wire logic pop
);

  pkt_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srrw_back.sv
// Back end: window classification, slot buffer, acknowledgements and in-order drain.
// Holds the window_size register and the output register. Uses srrw_pkg and the assert macros.
`default_nettype none

`include "selective_repeat_receiver_window_assert.svh"

module srrw_back import srrw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [WIN_W-1:0] cfg_data,
  input  wire logic             q_valid,
  input  wire pkt_t             head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_kind,
  output logic [31:0]           out_ack_number,
  output logic                  out_ack_flag,
  output logic [31:0]           out_ack_check,
  output logic [63:0]           out_low,
  output logic [63:0]           out_mid,
  output logic [31:0]           out_high,
  output logic                  out_last
);

  bstate_t              state_r, state_nxt;
  logic [SEQ_W-1:0]     exp_r, exp_nxt;
  logic [WIN_W-1:0]     cnt_r, cnt_nxt;
  logic [WIN_W-1:0]     win_r;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic                 out_valid_r;
  logic                 kind_r, flag_r, last_r;
  logic [31:0]          num_r, chk_r;
  logic [63:0]          low_r, mid_r;
  logic [31:0]          high_r;

  logic [63:0]          slot_low_r  [SLOT_COUNT];
  logic [63:0]          slot_mid_r  [SLOT_COUNT];
  logic [31:0]          slot_high_r [SLOT_COUNT];
  logic [63:0]          rd_low_r, rd_mid_r;
  logic [31:0]          rd_high_r;

  logic [WIN_W-1:0]     win_eff;
  logic [32:0]          diff;
  logic                 below, beyond, is_exp;
  logic [SLOT_W-1:0]    wr_idx, rd_idx;
  logic                 out_free;
  logic                 wr_en, rd_en;
  logic                 ld, ld_kind, ld_flag, ld_last;
  logic [31:0]          ld_chk;

  assign cfg_ready = 1'b1;
  assign win_eff   = (win_r > WIN_MAX) ? WIN_MAX : win_r;
  assign diff      = {head.seq[31], head.seq} - {2'b00, exp_r};
  assign below     = diff[32];
  assign beyond    = !below && ((diff[31:WIN_W] != '0) || (diff[WIN_W-1:0] >= win_eff));
  assign is_exp    = (diff == '0);
  assign wr_idx    = head.seq[SLOT_W-1:0];
  assign rd_idx    = exp_r[SLOT_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign ld_chk    = head.seq + ACK_SPACE + {31'b0, ld_flag};

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    ld        = 1'b0;
    ld_kind   = KIND_ACK;
    ld_flag   = FLAG_DUP;
    ld_last   = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && (beyond || out_free)) begin
          pop = 1'b1;
          if (below) begin
            ld = 1'b1;
          end else if (!beyond) begin
            ld                = 1'b1;
            ld_flag           = FLAG_WINDOW;
            ld_last           = !is_exp;
            wr_en             = 1'b1;
            valid_nxt[wr_idx] = 1'b1;
            if (is_exp) begin
              cnt_nxt   = '0;
              state_nxt = B_READ;
            end
          end
        end
      end
      B_READ: begin
        rd_en             = 1'b1;
        valid_nxt[rd_idx] = 1'b0;
        exp_nxt           = exp_r + 1'b1;
        cnt_nxt           = cnt_r + 1'b1;
        state_nxt         = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_DATA;
          ld_last   = !valid_r[rd_idx] || (cnt_r == win_eff);
          state_nxt = ld_last ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      exp_r       <= '0;
      cnt_r       <= '0;
      win_r       <= WIN_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        win_r <= cfg_data;
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_low_r[wr_idx]  <= head.plo;
      slot_mid_r[wr_idx]  <= head.pmid;
      slot_high_r[wr_idx] <= head.phi;
    end
    if (rd_en) begin
      rd_low_r  <= slot_low_r[rd_idx];
      rd_mid_r  <= slot_mid_r[rd_idx];
      rd_high_r <= slot_high_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r <= ld_kind;
      last_r <= ld_last;
      if (ld_kind == KIND_DATA) begin
        num_r  <= '0;
        flag_r <= FLAG_DUP;
        chk_r  <= '0;
        low_r  <= rd_low_r;
        mid_r  <= rd_mid_r;
        high_r <= rd_high_r;
      end else begin
        num_r  <= head.seq;
        flag_r <= ld_flag;
        chk_r  <= ld_chk;
        low_r  <= '0;
        mid_r  <= '0;
        high_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_ack_number = num_r;
  assign out_ack_flag   = flag_r;
  assign out_ack_check  = chk_r;
  assign out_low        = low_r;
  assign out_mid        = mid_r;
  assign out_high       = high_r;
  assign out_last       = last_r;

  `SRRW_ASSERT_NOW(a_read_slot_buffered, state_r == B_READ, valid_r[rd_idx], "drain read of empty slot")
  `SRRW_ASSERT_NEXT(a_read_then_send, state_r == B_READ, state_r == B_SEND, "drain read not followed by send")
  `SRRW_ASSERT_NOW(a_drain_in_window, state_r == B_READ, cnt_r < win_eff, "drain ran past the window")

endmodule

`default_nettype wire

FILE: hw/rtl/selective_repeat_receiver_window.sv
// Selective-repeat receiver window, top level.
// Input channel (in_valid / in_stall) takes one packet request per accepted cycle:
// sequence number, ack field, checksum and a 20-byte payload.
// Output channel (out_valid / out_stall) returns result requests: an acknowledgement
// (out_kind 0) and, for the expected packet, each buffered payload in order (out_kind 1).
// out_last marks the final result of a packet. Failed checksums and packets beyond
// the window produce nothing.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) sets the window width;
// write it only while the block is idle.
// The first result passes through the checksum stage register, the queue and then the
// output register. The back end takes packets from the queue only while idle, and
// delivers each buffered payload by a slot memory read (B_READ) followed by a load of
// the output register (B_SEND); the checksum front end takes a new packet every cycle
// while the two-entry queue has room.
// Reset (synchronous, rst_n low) empties the queue and all slots, sets the expected
// sequence number to zero and the window width to 32.
// When out_stall is high with out_valid set, the output register holds; the back end then
// stops loading results, the queue fills and in_stall rises to hold off the sender.
// Depends on srrw_pkg, srrw_front, srrw_queue and srrw_back.
`default_nettype none

module selective_repeat_receiver_window import srrw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [WIN_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_seq_num,
  input  wire logic signed [31:0] in_ack_field,
  input  wire logic signed [31:0] in_check_value,
  input  wire logic [63:0]        in_payload_low,
  input  wire logic [63:0]        in_payload_mid,
  input  wire logic [31:0]        in_payload_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic signed [31:0]      out_ack_number,
  output logic                    out_ack_flag,
  output logic signed [31:0]      out_ack_check,
  output logic [63:0]             out_low,
  output logic [63:0]             out_mid,
  output logic [31:0]             out_high,
  output logic                    out_last
);

  logic push, q_full, q_valid, pop;
  pkt_t push_pkt, head;

  srrw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .seq_num      (in_seq_num),
    .ack_field    (in_ack_field),
    .check_value  (in_check_value),
    .payload_low  (in_payload_low),
    .payload_mid  (in_payload_mid),
    .payload_high (in_payload_high),
    .push         (push),
    .push_pkt     (push_pkt),
    .q_full       (q_full)
  );

  srrw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop)
  );

  srrw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_ack_number (out_ack_number),
    .out_ack_flag   (out_ack_flag),
    .out_ack_check  (out_ack_check),
    .out_low        (out_low),
    .out_mid        (out_mid),
    .out_high       (out_high),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

FILE: bench/tb_selective_repeat_receiver_window.sv
// Self-checking testbench for the selective-repeat receiver window.
// Predicts acks and in-order deliveries per packet and checks them under random idling.
// Depends on srrw_pkg and the selective_repeat_receiver_window RTL.
module tb_selective_repeat_receiver_window import srrw_pkg::*; ();

  localparam int SETTLE_CYCLES = 24;

  typedef enum int {
    PAY_RANDOM,
    PAY_ZERO,
    PAY_ONES
  } fill_t;

  typedef struct {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] check;
    logic [63:0] plo;
    logic [63:0] pmid;
    logic [31:0] phi;
  } packet_t;

  typedef struct {
    logic        kind;
    logic [31:0] ack_number;
    logic        ack_flag;
    logic [31:0] ack_check;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_seq_num = '0;
  logic signed [31:0] in_ack_field = '0;
  logic signed [31:0] in_check_value = '0;
  logic [63:0] in_payload_low = '0;
  logic [63:0] in_payload_mid = '0;
  logic [31:0] in_payload_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic signed [31:0] out_ack_number;
  logic out_ack_flag;
  logic signed [31:0] out_ack_check;
  logic [63:0] out_low;
  logic [63:0] out_mid;
  logic [31:0] out_high;
  logic out_last;

  logic [WIN_W-1:0] window_reg;
  logic [SEQ_W-1:0] next_seq;
  logic slot_full [SLOT_COUNT];
  logic [63:0] slot_lo [SLOT_COUNT];
  logic [63:0] slot_mid [SLOT_COUNT];
  logic [31:0] slot_hi [SLOT_COUNT];
  reply_t pending_replies[$];
  int errors = 0;
  int in_gap_max = 14;
  int out_stall_max = 14;
  int stall_left = 0;

  selective_repeat_receiver_window u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_seq_num(in_seq_num),
    .in_ack_field(in_ack_field),
    .in_check_value(in_check_value),
    .in_payload_low(in_payload_low),
    .in_payload_mid(in_payload_mid),
    .in_payload_high(in_payload_high),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_ack_number(out_ack_number),
    .out_ack_flag(out_ack_flag),
    .out_ack_check(out_ack_check),
    .out_low(out_low),
    .out_mid(out_mid),
    .out_high(out_high),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] packet_sum(input packet_t p);
    logic [31:0] acc;
    acc = p.seq + p.ack;
    for (int i = 0; i < 8; i++) begin
      acc = acc + {{24{p.plo[8*i+7]}}, p.plo[8*i +: 8]};
      acc = acc + {{24{p.pmid[8*i+7]}}, p.pmid[8*i +: 8]};
    end
    for (int i = 0; i < 4; i++) begin
      acc = acc + {{24{p.phi[8*i+7]}}, p.phi[8*i +: 8]};
    end
    return acc;
  endfunction

  function automatic packet_t make_packet(input logic [31:0] seq, input logic good,
                                          input fill_t fill);
    packet_t p;
    p.seq = seq;
    p.ack = $urandom();
    case (fill)
      PAY_ZERO: begin
        p.plo = '0;
        p.pmid = '0;
        p.phi = '0;
      end
      PAY_ONES: begin
        p.plo = '1;
        p.pmid = '1;
        p.phi = '1;
      end
      default: begin
        p.plo = {$urandom(), $urandom()};
        p.pmid = {$urandom(), $urandom()};
        p.phi = $urandom();
      end
    endcase
    p.check = packet_sum(p);
    if (!good) begin
      p.check = p.check + ($urandom() | 32'h1);
    end
    return p;
  endfunction

  // Updates the window state for one accepted request and queues the results it causes.
  task automatic predict_receiver(input packet_t p);
    reply_t burst[$];
    reply_t r;
    longint sv;
    longint ev;
    int weff;
    logic [4:0] slot;
    if (packet_sum(p) != p.check) begin
      return;
    end
    weff = (window_reg > SLOT_COUNT) ? SLOT_COUNT : window_reg;
    sv = longint'($signed(p.seq));
    ev = longint'({1'b0, next_seq});
    r = '{KIND_ACK, p.seq, FLAG_DUP, p.seq + ACK_SPACE, '0, '0, '0, 1'b1};
    if (sv < ev) begin
      pending_replies.push_back(r);
      return;
    end
    if (sv >= ev + weff) begin
      return;
    end
    slot = p.seq[4:0];
    slot_full[slot] = 1'b1;
    slot_lo[slot] = p.plo;
    slot_mid[slot] = p.pmid;
    slot_hi[slot] = p.phi;
    r.ack_flag = FLAG_WINDOW;
    r.ack_check = p.seq + ACK_SPACE + 32'd1;
    r.last = 1'b0;
    burst.push_back(r);
    if (sv == ev) begin
      for (int k = 0; k < weff; k++) begin
        slot = next_seq[4:0];
        if (!slot_full[slot]) begin
          break;
        end
        burst.push_back('{KIND_DATA, '0, FLAG_DUP, '0, slot_lo[slot], slot_mid[slot],
                          slot_hi[slot], 1'b0});
        slot_full[slot] = 1'b0;
        next_seq = next_seq + 1'b1;
      end
    end
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) begin
      pending_replies.push_back(burst[i]);
    end
  endtask

  task automatic send_packet(input packet_t p);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seq_num <= p.seq;
    in_ack_field <= p.ack;
    in_check_value <= p.check;
    in_payload_low <= p.plo;
    in_payload_mid <= p.pmid;
    in_payload_high <= p.phi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_receiver(p);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] width);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    window_reg = width;
  endtask

  task automatic test_checksum_and_bounds();
    send_packet(make_packet(32'd0, 1'b0, PAY_RANDOM));
    send_packet(make_packet(32'h8000_0000, 1'b1, PAY_ONES));
    send_packet(make_packet(32'h7FFF_FFFF, 1'b1, PAY_ZERO));
    send_packet(make_packet(32'd32, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'hFFFF_FFFF, 1'b1, PAY_RANDOM));
  endtask

  task automatic test_reorder_and_drain();
    send_packet(make_packet(32'd31, 1'b1, PAY_ZERO));
    send_packet(make_packet(32'd2, 1'b1, PAY_ONES));
    send_packet(make_packet(32'd1, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'd2, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'd0, 1'b1, PAY_ONES));
    send_packet(make_packet(32'd1, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'd3, 1'b1, PAY_ZERO));
  endtask

  task automatic test_narrow_window();
    write_window(6'd8);
    for (int s = 11; s >= 5; s--) begin
      send_packet(make_packet(32'(s), 1'b1, PAY_RANDOM));
    end
    send_packet(make_packet(32'd12, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'd4, 1'b1, PAY_RANDOM));
    write_window(6'd1);
    send_packet(make_packet(32'd13, 1'b1, PAY_RANDOM));
    send_packet(make_packet(32'd12, 1'b1, PAY_RANDOM));
  endtask

  // Mostly shuffled runs of in-window requests, mixed with duplicates, packets past
  // the window, corrupted checksums and arbitrary sequence numbers.
  task automatic test_random_traffic(input logic [WIN_W-1:0] width, input int count,
                                     input int gap_max, input int stall_max);
    logic [31:0] burst[$];
    logic [31:0] seq;
    logic [31:0] swap;
    fill_t fill;
    int sent;
    int pick;
    int span;
    int k;
    int weff;
    logic good;
    write_window(width);
    in_gap_max = gap_max;
    out_stall_max = stall_max;
    weff = (width > SLOT_COUNT) ? SLOT_COUNT : width;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      fill = ($urandom_range(0, 7) == 0) ? PAY_ONES : PAY_RANDOM;
      if (pick < 60 && weff > 0) begin
        span = $urandom_range(1, weff);
        burst.delete();
        for (int j = 0; j < span; j++) begin
          burst.push_back({1'b0, next_seq} + 32'(j));
        end
        for (int j = span - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          swap = burst[j];
          burst[j] = burst[k];
          burst[k] = swap;
        end
        if ($urandom_range(0, 9) == 0) begin
          burst.insert($urandom_range(0, span), burst[$urandom_range(0, span - 1)]);
        end
        foreach (burst[j]) begin
          send_packet(make_packet(burst[j], 1'b1, fill));
        end
        sent += burst.size();
      end else begin
        good = 1'b1;
        if (pick < 75) begin
          if (next_seq > 8 && $urandom_range(0, 1) == 1) begin
            seq = {1'b0, next_seq} - 32'($urandom_range(1, 8));
          end else begin
            seq = {1'b1, 31'($urandom())};
          end
        end else if (pick < 85) begin
          seq = {1'b0, next_seq} + 32'(weff) + 32'($urandom_range(0, 40));
        end else if (pick < 93) begin
          seq = {1'b0, next_seq} + 32'($urandom_range(0, 8));
          good = 1'b0;
        end else begin
          seq = $urandom();
        end
        send_packet(make_packet(seq, good, fill));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result: out_kind %0h out_ack_number %0h", out_kind,
                 out_ack_number);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind expected %0h actual %0h", want.kind, out_kind);
            errors++;
          end
          if (out_ack_number !== want.ack_number) begin
            $error("out_ack_number expected %0h actual %0h", want.ack_number,
                   out_ack_number);
            errors++;
          end
          if (out_ack_flag !== want.ack_flag) begin
            $error("out_ack_flag expected %0h actual %0h", want.ack_flag, out_ack_flag);
            errors++;
          end
          if (out_ack_check !== want.ack_check) begin
            $error("out_ack_check expected %0h actual %0h", want.ack_check, out_ack_check);
            errors++;
          end
          if (out_low !== want.lo) begin
            $error("out_low expected %0h actual %0h", want.lo, out_low);
            errors++;
          end
          if (out_mid !== want.mid) begin
            $error("out_mid expected %0h actual %0h", want.mid, out_mid);
            errors++;
          end
          if (out_high !== want.hi) begin
            $error("out_high expected %0h actual %0h", want.hi, out_high);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last expected %0h actual %0h", want.last, out_last);
            errors++;
          end
        end
        stall_left = $urandom_range(0, out_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    window_reg = WIN_RESET;
    next_seq = '0;
    foreach (slot_full[i]) begin
      slot_full[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_checksum_and_bounds();
    test_reorder_and_drain();
    test_narrow_window();
    test_random_traffic(WIN_MAX, 45, 14, 14);
    test_random_traffic(6'd1, 25, 14, 14);
    test_random_traffic(6'd63, 35, 0, 0);
    test_random_traffic(6'd5, 30, 14, 3);
    test_random_traffic(6'd0, 10, 3, 14);
    test_random_traffic(WIN_RESET, 40, 2, 14);
    wait_for_idle();
    if (errors == 0) begin
      $display("PASS selective_repeat_receiver_window");
    end else begin
      $display("FAIL selective_repeat_receiver_window");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("FAIL selective_repeat_receiver_window");
    $finish;
  end

endmodule
